[sv/pdr_pkg.sv]
// Shared widths, constants, the CORDIC angle table and controller/datapath link types.
`default_nettype none

package pdr_pkg;

  // Request field widths
  localparam int FWD_W   = 15;
  localparam int LAT_W   = 15;
  localparam int YAW_W   = 18;
  localparam int STEP_W  = 16;
  localparam int IN_W    = FWD_W + LAT_W + YAW_W + STEP_W;

  // Result field widths
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int ELAP_W  = 40;
  localparam int OUT_W   = 2 * POS_W + HEAD_W + ELAP_W;

  // Datapath widths
  localparam int SPD_W   = FWD_W + 1;          // speed after optional negation
  localparam int XW      = 33;                 // CORDIC x, y, z
  localparam int PW      = SPD_W + XW;         // speed * sin/cos
  localparam int SW      = PW + 1;             // sum of two products
  localparam int DW      = SW + STEP_W + 1;    // sum * step time
  localparam int HPW     = YAW_W + STEP_W + 1; // yaw rate * step time
  localparam int QW      = DW - 38;            // rounded position increment
  localparam int SATW    = POS_W + 2;          // saturating add

  localparam int CORDIC_MAX = 24;
  localparam int IDX_W      = 5;

  localparam logic signed [XW-1:0] CORDIC_ONE = 33'sd652032874;
  localparam logic signed [XW-1:0] Z_QTR      = 33'sd1073741824;
  localparam logic signed [XW-1:0] Z_HALF     = 33'sd2147483648;
  localparam logic signed [DW-1:0] POS_RND    = 67'sd137438953472;
  localparam logic signed [HPW-1:0] HEAD_RND  = 35'sd32768;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  // Controller commands to the datapath, one active per cycle
  typedef struct packed {
    logic             load;  // take the request, set up the rotation
    logic             iter;  // one CORDIC iteration
    logic             mul;   // speed times cos/sin, yaw rate times step
    logic             sum;   // combine rotated components
    logic             prod;  // scale by step time
    logic             rnd;   // round position increments
    logic             upd;   // update state and load the result register
    logic [IDX_W-1:0] idx;   // iteration index
  } pdr_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register full and not being taken
  } pdr_sts_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] pdr_atan(input logic [IDX_W-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[sv/pdr_ctrl.sv]
// Sequencing state machine: accept, CORDIC iterations, multiply, sum, scale, round, update.
`default_nettype none

module pdr_ctrl #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output pdr_pkg::pdr_cmd_t      cmd,
  input  wire pdr_pkg::pdr_sts_t sts
);
  import pdr_pkg::*;

  localparam int N_ITER = (ANGLE_BITS > CORDIC_MAX) ? CORDIC_MAX : ANGLE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_ITER - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ROT  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_PROD = 7'b0010000,
    S_RND  = 7'b0100000,
    S_UPD  = 7'b1000000
  } pdr_state_t;

  pdr_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        cmd.iter = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/pdr_dp.sv]
// Datapath: shared CORDIC stage, multipliers, rounding, state update with saturating position.
`default_nettype none

module pdr_dp #(
  parameter int TIME_BITS = 40
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire pdr_pkg::pdr_cmd_t                     cmd,
  output pdr_pkg::pdr_sts_t                          sts,
  input  wire logic signed [pdr_pkg::FWD_W-1:0]      fwd_speed,
  input  wire logic signed [pdr_pkg::LAT_W-1:0]      lat_speed,
  input  wire logic signed [pdr_pkg::YAW_W-1:0]      yaw_rate,
  input  wire logic        [pdr_pkg::STEP_W-1:0]     step_time,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [pdr_pkg::POS_W-1:0]           north_out,
  output logic signed [pdr_pkg::POS_W-1:0]           east_out,
  output logic signed [pdr_pkg::HEAD_W-1:0]          heading_out,
  output logic        [pdr_pkg::ELAP_W-1:0]          elapsed_out
);
  import pdr_pkg::*;

  // architectural state
  logic signed [POS_W-1:0]  north_r, east_r;
  logic signed [HEAD_W-1:0] head_r;
  logic [TIME_BITS-1:0]     elap_r;

  // request and working registers
  logic signed [SPD_W-1:0]  u_r, v_r;
  logic signed [YAW_W-1:0]  r_r;
  logic [STEP_W-1:0]        dt_r;
  logic signed [XW-1:0]     x_r, y_r, z_r;
  logic signed [PW-1:0]     uc_r, vs_r, us_r, vc_r;
  logic signed [SW-1:0]     dn_sum_r, de_sum_r;
  logic signed [DW-1:0]     dn_r, de_r;
  logic signed [HPW-1:0]    hp_r;
  logic signed [HEAD_W-1:0] hinc_r;
  logic signed [QW-1:0]     dn_q_r, de_q_r;
  logic                     out_valid_r;

  // result register
  logic signed [POS_W-1:0]  out_north_r, out_east_r;
  logic signed [HEAD_W-1:0] out_head_r;
  logic [ELAP_W-1:0]        out_elap_r;

  // fold the heading into [-quarter, quarter] turn
  logic signed [XW-1:0]     z_full, z_fold;
  logic                     fold;
  logic signed [SPD_W-1:0]  u_ext, v_ext;

  always_comb begin
    z_full = {head_r[HEAD_W-1], head_r, 16'b0};
    fold   = 1'b0;
    z_fold = z_full;
    if (z_full > Z_QTR) begin
      z_fold = z_full - Z_HALF;
      fold   = 1'b1;
    end else if (z_full < -Z_QTR) begin
      z_fold = z_full + Z_HALF;
      fold   = 1'b1;
    end
    u_ext = {fwd_speed[FWD_W-1], fwd_speed};
    v_ext = {lat_speed[LAT_W-1], lat_speed};
  end

  // one CORDIC iteration
  logic signed [XW-1:0] sx, sy, at, x_it, y_it, z_it;

  always_comb begin
    sx = x_r >>> cmd.idx;
    sy = y_r >>> cmd.idx;
    at = signed'({1'b0, pdr_atan(cmd.idx)});
    if (!z_r[XW-1]) begin
      x_it = x_r - sy;
      y_it = y_r + sx;
      z_it = z_r - at;
    end else begin
      x_it = x_r + sy;
      y_it = y_r - sx;
      z_it = z_r + at;
    end
  end

  // rounding and saturating update
  logic signed [DW-1:0]    dn_rf, de_rf;
  logic signed [HPW-1:0]   hp_rf;
  logic signed [SATW-1:0]  n_sum, e_sum;
  logic signed [POS_W-1:0] north_nxt, east_nxt;
  logic signed [HEAD_W-1:0] head_nxt;
  logic [TIME_BITS-1:0]    elap_nxt;
  logic [ELAP_W-1:0]       elap_wide;
  logic signed [STEP_W:0]  dt_s;

  always_comb begin
    dt_s  = signed'({1'b0, dt_r});
    dn_rf = dn_r + POS_RND;
    de_rf = de_r + POS_RND;
    hp_rf = hp_r + HEAD_RND;
    n_sum = SATW'(north_r) + SATW'(dn_q_r);
    e_sum = SATW'(east_r) + SATW'(de_q_r);
    if (n_sum[SATW-1:POS_W-1] == '0 || n_sum[SATW-1:POS_W-1] == '1) begin
      north_nxt = n_sum[POS_W-1:0];
    end else begin
      north_nxt = n_sum[SATW-1] ? POS_MIN : POS_MAX;
    end
    if (e_sum[SATW-1:POS_W-1] == '0 || e_sum[SATW-1:POS_W-1] == '1) begin
      east_nxt = e_sum[POS_W-1:0];
    end else begin
      east_nxt = e_sum[SATW-1] ? POS_MIN : POS_MAX;
    end
    head_nxt = head_r + hinc_r;
    elap_nxt = elap_r + TIME_BITS'(dt_r);
  end

  if (TIME_BITS >= ELAP_W) begin : g_elap_cut
    assign elap_wide = elap_nxt[ELAP_W-1:0];
  end else begin : g_elap_ext
    assign elap_wide = {{(ELAP_W - TIME_BITS){1'b0}}, elap_nxt};
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r  <= fold ? -u_ext : u_ext;
      v_r  <= fold ? -v_ext : v_ext;
      r_r  <= yaw_rate;
      dt_r <= step_time;
      x_r  <= CORDIC_ONE;
      y_r  <= '0;
      z_r  <= z_fold;
    end
    if (cmd.iter) begin
      x_r <= x_it;
      y_r <= y_it;
      z_r <= z_it;
    end
    if (cmd.mul) begin
      uc_r <= PW'(u_r) * PW'(x_r);
      vs_r <= PW'(v_r) * PW'(y_r);
      us_r <= PW'(u_r) * PW'(y_r);
      vc_r <= PW'(v_r) * PW'(x_r);
      hp_r <= HPW'(r_r) * HPW'(dt_s);
    end
    if (cmd.sum) begin
      dn_sum_r <= SW'(uc_r) - SW'(vs_r);
      de_sum_r <= SW'(us_r) + SW'(vc_r);
      hinc_r   <= hp_rf[HEAD_W+15:16];
    end
    if (cmd.prod) begin
      dn_r <= DW'(dn_sum_r) * DW'(dt_s);
      de_r <= DW'(de_sum_r) * DW'(dt_s);
    end
    if (cmd.rnd) begin
      dn_q_r <= dn_rf[DW-1:38];
      de_q_r <= de_rf[DW-1:38];
    end
    if (cmd.upd) begin
      out_north_r <= north_nxt;
      out_east_r  <= east_nxt;
      out_head_r  <= head_nxt;
      out_elap_r  <= elap_wide;
    end
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      north_r     <= '0;
      east_r      <= '0;
      head_r      <= '0;
      elap_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        north_r     <= north_nxt;
        east_r      <= east_nxt;
        head_r      <= head_nxt;
        elap_r      <= elap_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign north_out    = out_north_r;
  assign east_out     = out_east_r;
  assign heading_out  = out_head_r;
  assign elapsed_out  = out_elap_r;

endmodule

`default_nettype wire

[sv/planar_dead_reckoning_integrator.sv]
// Top level of the planar dead-reckoning integrator: controller, datapath, assertions.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | speeds, yaw rate, step time (64 bits)
//  out_    | out | out_tvalid/tready  | north, east, heading, elapsed (120 bits)
//
// A request runs from acceptance to the next acceptance through these steps: load,
// the CORDIC iterations on the single shared rotation stage, then multiply, sum,
// scale, round and update; no new request is taken until the update is done.
// The result register holds a finished result while the next request is taken;
// the update step waits only if that register is still full and not being read.
// Reset (rst_n low, synchronous) clears position, heading, elapsed time and all
// control state; working registers carry no reset.
`default_nettype none

module planar_dead_reckoning_integrator #(
  parameter int ANGLE_BITS = 16,  // CORDIC iterations, 10 to 24
  parameter int TIME_BITS  = 40   // width of the elapsed-time counter, 24 to 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // fwd_speed[14:0], lat_speed[29:15], yaw_rate[47:30], step_time[63:48]
  input  wire logic [pdr_pkg::IN_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // north_out[31:0], east_out[63:32], heading_out[79:64], elapsed_out[119:80]
  output logic [pdr_pkg::OUT_W-1:0]          out_tdata
);
  import pdr_pkg::*;

  pdr_cmd_t cmd;
  pdr_sts_t sts;

  logic signed [POS_W-1:0]  north_out, east_out;
  logic signed [HEAD_W-1:0] heading_out;
  logic [ELAP_W-1:0]        elapsed_out;

  // sequencer
  pdr_ctrl #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // arithmetic, state and result register
  pdr_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .fwd_speed   (signed'(in_tdata[14:0])),
    .lat_speed   (signed'(in_tdata[29:15])),
    .yaw_rate    (signed'(in_tdata[47:30])),
    .step_time   (in_tdata[63:48]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .north_out   (north_out),
    .east_out    (east_out),
    .heading_out (heading_out),
    .elapsed_out (elapsed_out)
  );

  // pack the result, first field lowest
  assign out_tdata = {elapsed_out, heading_out, east_out, north_out};

`ifndef NO_ASSERTIONS
  // after taking a request the block is busy until its update is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while previous one still in progress");

  // the update never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten while stalled");

  // the controller issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.iter, cmd.mul, cmd.sum, cmd.prod, cmd.rnd, cmd.upd}))
    else $error("more than one datapath command active");

  // a new result appears only the cycle after an update
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.upd))
    else $error("result valid raised without an update");
`endif

endmodule

`default_nettype wire
